FILE: src/dsdt_pkg.sv
package dsdt_pkg;

    localparam int CMD_W   = 4;
    localparam int IDX_W   = 5;
    localparam int STAMP_W = 64;
    localparam int CNT_W   = 32;
    localparam int LIMIT_W = 8;
    localparam int RUN_W   = 8;
    localparam int STATE_W = 3;
    localparam int ACT_W   = 2;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 104;

    localparam logic [CMD_W-1:0] CMD_OUT_QUEUED   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_OUT_DEQUEUED = 4'd1;
    localparam logic [CMD_W-1:0] CMD_CAP_DONE     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_CAP_ERROR    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CAP_LAST     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DRAIN        = 4'd5;
    localparam logic [CMD_W-1:0] CMD_RESCHANGE    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_RESTART      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT      = 4'd8;
    localparam logic [CMD_W-1:0] CMD_NEWSEQ       = 4'd9;

    localparam logic [ACT_W-1:0] ACT_NONE     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RECOVERY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FAILED   = 2'd2;

    localparam logic [STATE_W-1:0] STATE_RUNNING  = 3'd0;
    localparam logic [STATE_W-1:0] STATE_DRAINING = 3'd1;
    localparam logic [STATE_W-1:0] STATE_RECONF   = 3'd2;
    localparam logic [STATE_W-1:0] STATE_PENDING  = 3'd3;
    localparam logic [STATE_W-1:0] STATE_FAILED   = 3'd4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd3;
    localparam logic [RUN_W-1:0]   RUN_MAX     = 8'hFF;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [4:0] {
        MODE_RUNNING  = 5'b00001,
        MODE_DRAINING = 5'b00010,
        MODE_RECONF   = 5'b00100,
        MODE_PENDING  = 5'b01000,
        MODE_FAILED   = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   buffer_index;
        logic [STAMP_W-1:0] capture_timestamp;
        logic               at_startup;
        logic               recover_ok;
    } event_t;

    typedef struct packed {
        logic               accepted;
        logic [ACT_W-1:0]   timeout_action;
        logic [STATE_W-1:0] session_state;
        logic [CNT_W-1:0]   completed_total;
        logic [CNT_W-1:0]   error_total;
        logic [CNT_W-1:0]   zero_stamp_errors;
    } result_t;

    function automatic logic [STATE_W-1:0] mode_code(mode_t m);
        logic [STATE_W-1:0] code;
        case (m)
            MODE_RUNNING:  code = STATE_RUNNING;
            MODE_DRAINING: code = STATE_DRAINING;
            MODE_RECONF:   code = STATE_RECONF;
            MODE_PENDING:  code = STATE_PENDING;
            MODE_FAILED:   code = STATE_FAILED;
            default:       code = STATE_RUNNING;
        endcase
        return code;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

FILE: src/dsdt_core.sv
module dsdt_core
    import dsdt_pkg::*;
#(
    parameter int NUM_BUFFERS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic               ev_fire,
    input  event_t             ev,
    output result_t            res
);

    typedef logic [NUM_BUFFERS-1:0] map_t;

    mode_t              mode_reg, mode_next;
    map_t               queued_reg, queued_next;
    map_t               drain_map_reg, drain_map_next;
    logic               drain_on_reg, drain_on_next;
    logic               last_reg, last_next;
    logic               oss_reg, oss_next;
    logic               rec_used_reg, rec_used_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [CNT_W-1:0]   completed_reg, completed_next;
    logic [CNT_W-1:0]   error_reg, error_next;
    logic [CNT_W-1:0]   zero_reg, zero_next;
    logic [LIMIT_W-1:0] limit_reg;

    logic               ok;
    logic [ACT_W-1:0]   action;
    logic               idx_ok;
    map_t               bit_mask;
    logic               can_start;
    logic [RUN_W-1:0]   run_sat;

    always_comb begin
        mode_next      = mode_reg;
        queued_next    = queued_reg;
        drain_map_next = drain_map_reg;
        drain_on_next  = drain_on_reg;
        last_next      = last_reg;
        oss_next       = oss_reg;
        rec_used_next  = rec_used_reg;
        run_next       = run_reg;
        completed_next = completed_reg;
        error_next     = error_reg;
        zero_next      = zero_reg;
        ok             = 1'b0;
        action         = ACT_NONE;

        idx_ok    = int'(ev.buffer_index) < NUM_BUFFERS;
        bit_mask  = idx_ok ? (map_t'(1) << ev.buffer_index) : '0;
        can_start = (mode_reg != MODE_FAILED) && (mode_reg != MODE_PENDING) && !drain_on_reg;
        run_sat   = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;

        case (ev.cmd)
            CMD_OUT_QUEUED: begin
                if (idx_ok && mode_reg == MODE_RUNNING && (queued_reg & bit_mask) == '0) begin
                    queued_next = queued_reg | bit_mask;
                    oss_next    = 1'b1;
                    ok          = 1'b1;
                end
            end
            CMD_OUT_DEQUEUED: begin
                if (idx_ok && mode_reg != MODE_FAILED && (queued_reg & bit_mask) != '0) begin
                    queued_next    = queued_reg & ~bit_mask;
                    drain_map_next = drain_map_reg & ~bit_mask;
                    if (drain_on_reg && last_reg && drain_map_next == '0) begin
                        mode_next = MODE_PENDING;
                    end
                    ok = 1'b1;
                end
            end
            CMD_CAP_DONE: begin
                if (mode_reg != MODE_FAILED) begin
                    completed_next = sat_inc(completed_reg);
                    run_next       = '0;
                    ok             = 1'b1;
                end
            end
            CMD_CAP_ERROR: begin
                if (mode_reg != MODE_FAILED) begin
                    error_next = sat_inc(error_reg);
                    if (ev.capture_timestamp == '0) begin
                        zero_next = sat_inc(zero_reg);
                    end
                    ok = 1'b1;
                end
            end
            CMD_CAP_LAST: begin
                if (mode_reg != MODE_FAILED && drain_on_reg && !last_reg) begin
                    last_next = 1'b1;
                    if (drain_map_reg == '0) begin
                        mode_next = MODE_PENDING;
                    end
                    ok = 1'b1;
                end
            end
            CMD_DRAIN: begin
                if (mode_reg == MODE_DRAINING || mode_reg == MODE_RECONF) begin
                    ok = 1'b1;
                end else if (mode_reg == MODE_RUNNING && !oss_reg) begin
                    ok = 1'b0;
                end else if (can_start) begin
                    drain_on_next  = 1'b1;
                    last_next      = 1'b0;
                    drain_map_next = queued_reg;
                    mode_next      = MODE_DRAINING;
                    ok             = 1'b1;
                end
            end
            CMD_RESCHANGE: begin
                if (mode_reg == MODE_FAILED) begin
                    ok = 1'b0;
                end else if (mode_reg == MODE_PENDING) begin
                    ok = 1'b1;
                end else if (drain_on_reg || can_start) begin
                    if (!drain_on_reg) begin
                        drain_on_next  = 1'b1;
                        last_next      = 1'b0;
                        drain_map_next = queued_reg;
                    end
                    mode_next = MODE_RECONF;
                    if (drain_on_next && last_next && drain_map_next == '0) begin
                        mode_next = MODE_PENDING;
                    end
                    ok = 1'b1;
                end
            end
            CMD_RESTART: begin
                if (mode_reg == MODE_PENDING && last_reg && drain_map_reg == '0) begin
                    mode_next      = MODE_RUNNING;
                    drain_on_next  = 1'b0;
                    last_next      = 1'b0;
                    drain_map_next = '0;
                    oss_next       = 1'b0;
                    ok             = 1'b1;
                end
            end
            CMD_TIMEOUT: begin
                if (mode_reg == MODE_FAILED) begin
                    action = ACT_FAILED;
                end else begin
                    ok = 1'b1;
                    if (!ev.at_startup) begin
                        run_next = run_sat;
                    end
                    if (!ev.at_startup && run_sat >= limit_reg) begin
                        mode_next      = MODE_FAILED;
                        drain_on_next  = 1'b0;
                        drain_map_next = '0;
                        action         = ACT_FAILED;
                    end else if (ev.recover_ok && !rec_used_reg && !drain_on_reg) begin
                        rec_used_next = 1'b1;
                        // pending mode blocks the drain itself, but the request still counts
                        if (can_start) begin
                            drain_on_next  = 1'b1;
                            last_next      = 1'b0;
                            drain_map_next = queued_reg;
                            mode_next      = MODE_DRAINING;
                        end
                        action = ACT_RECOVERY;
                    end
                end
            end
            CMD_NEWSEQ: begin
                mode_next      = MODE_RUNNING;
                queued_next    = '0;
                drain_map_next = '0;
                drain_on_next  = 1'b0;
                last_next      = 1'b0;
                run_next       = '0;
                rec_used_next  = 1'b0;
                oss_next       = 1'b0;
                ok             = 1'b1;
            end
            default: begin
            end
        endcase

        res.accepted          = ok;
        res.timeout_action    = action;
        res.session_state     = mode_code(mode_next);
        res.completed_total   = completed_next;
        res.error_total       = error_next;
        res.zero_stamp_errors = zero_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_RUNNING;
            queued_reg    <= '0;
            drain_map_reg <= '0;
            drain_on_reg  <= 1'b0;
            last_reg      <= 1'b0;
            oss_reg       <= 1'b0;
            rec_used_reg  <= 1'b0;
            run_reg       <= '0;
            completed_reg <= '0;
            error_reg     <= '0;
            zero_reg      <= '0;
        end else if (ev_fire) begin
            mode_reg      <= mode_next;
            queued_reg    <= queued_next;
            drain_map_reg <= drain_map_next;
            drain_on_reg  <= drain_on_next;
            last_reg      <= last_next;
            oss_reg       <= oss_next;
            rec_used_reg  <= rec_used_next;
            run_reg       <= run_next;
            completed_reg <= completed_next;
            error_reg     <= error_next;
            zero_reg      <= zero_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

endmodule

FILE: src/decode_session_drain_tracker_top.sv
// Channel  | Dir | Handshake         | Payload
// ---------+-----+-------------------+---------------------------------------------
// s_       | in  | s_tvalid/s_tready | s_tuser cmd, s_tdata event fields
// m_       | out | m_tvalid/m_tready | m_tdata result fields
// cfg_     | in  | cfg_we            | cfg_wdata timeout_limit
//
// One event per cycle sustained while m_tready is high; an event passes the input
// register, then the state update and result register, before m_tvalid rises.
// Session state is updated when the registered event moves into the result register.
// A stall on m_tready holds both stages; s_tready drops once both are full.
// aresetn is synchronous: it empties both stages and restores all session state.
module decode_session_drain_tracker_top
    import dsdt_pkg::*;
#(
    parameter int NUM_BUFFERS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [4:0] buffer_index, [68:5] capture_timestamp, [69] at_startup,
    // [70] recover_ok, [71] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [3:0] cmd
    input  logic [CMD_W-1:0]     s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] accepted, [2:1] timeout_action, [5:3] session_state,
    // [37:6] completed_total, [69:38] error_total, [101:70] zero_stamp_errors,
    // [103:102] zero
    output logic [M_TDATA_W-1:0] m_tdata,

    input  logic                 cfg_we,
    input  logic [LIMIT_W-1:0]   cfg_wdata
);

    logic    in_valid_reg, in_valid_next;
    event_t  in_event_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;
    result_t core_res;
    event_t  s_event;
    logic    advance;
    logic    fire;
    logic    take;

    assign s_event.cmd               = s_tuser;
    assign s_event.buffer_index      = s_tdata[4:0];
    assign s_event.capture_timestamp = s_tdata[68:5];
    assign s_event.at_startup        = s_tdata[69];
    assign s_event.recover_ok        = s_tdata[70];

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_event_reg <= s_event;
        end
        if (fire) begin
            out_result_reg <= core_res;
        end
    end

    dsdt_core #(
        .NUM_BUFFERS(NUM_BUFFERS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .ev_fire  (fire),
        .ev       (in_event_reg),
        .res      (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_result_reg.zero_stamp_errors,
                       out_result_reg.error_total,
                       out_result_reg.completed_total,
                       out_result_reg.session_state,
                       out_result_reg.timeout_action,
                       out_result_reg.accepted};

endmodule

FILE: src/dsdt_checker.sv
module dsdt_checker
    import dsdt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transfer changed");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[1]))
        else $error("bad timeout action code");

    // a failed timeout always leaves the session in failed state
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:1] == ACT_FAILED |-> m_tdata[5:3] == STATE_FAILED)
        else $error("timeout failure without failed state");

    // a recovery request is an accepted event
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:1] == ACT_RECOVERY |-> m_tdata[0])
        else $error("recovery requested on rejected event");

endmodule

bind decode_session_drain_tracker_top dsdt_checker u_dsdt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
